>>> rtl/rrel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrel_pkg
// Types, constants and opcode tables for the rip-relative displacement
// relocator.
// ----------------------------------------------------------------------------
package rrel_pkg;

  localparam int INSN_BYTES_DEF = 15;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] OP_ESCAPE    = 8'h0f;
  localparam logic [7:0] REX_MASK     = 8'hf0;
  localparam logic [7:0] REX_BASE     = 8'h40;
  localparam logic [7:0] MODRM_MASK   = 8'hc7;
  localparam logic [7:0] MODRM_RIPREL = 8'h05;

  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_ADSIZE = 8'h67;
  localparam logic [7:0] PFX_CS     = 8'h2e;
  localparam logic [7:0] PFX_DS     = 8'h3e;
  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_LOCK   = 8'hf0;
  localparam logic [7:0] PFX_REP    = 8'hf3;
  localparam logic [7:0] PFX_REPNE  = 8'hf2;

  // ModRM presence: row = opcode[7:4], bit = opcode[3:0]
  localparam logic [15:0] ONE_MODRM [16] = '{
    16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0000, 16'h0000, 16'h0A0C, 16'h0000,
    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h00F3, 16'hFF0F, 16'h0000, 16'hC0C0
  };
  localparam logic [15:0] TWO_MODRM [16] = '{
    16'hA00F, 16'h01FF, 16'hFF5F, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF07F,
    16'h0000, 16'hFFFF, 16'hF8F8, 16'hFCFF, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'h7FFF
  };

  typedef struct packed {
    logic [63:0] insn_low;
    logic [55:0] insn_high;
    logic [63:0] orig_address;
    logic [63:0] copy_address;
  } in_item_t;

  typedef struct packed {
    logic              rip_relative;
    logic [3:0]        disp_offset;
    logic signed [31:0] new_disp;
    logic              out_of_range;
    logic [63:0]       patched_low;
    logic [55:0]       patched_high;
  } out_item_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic        rip_relative;
    logic [3:0]  disp_offset;
    logic [31:0] disp;
    logic [63:0] delta;
    logic [63:0] insn_low;
    logic [55:0] insn_high;
  } mid_item_t;

  function automatic logic is_legacy_prefix(input logic [7:0] b);
    logic r;
    case (b)
      PFX_OPSIZE, PFX_ADSIZE, PFX_CS, PFX_DS, PFX_ES, PFX_FS,
      PFX_GS, PFX_SS, PFX_LOCK, PFX_REP, PFX_REPNE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rrel_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrel_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module rrel_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rrel_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrel_front
// Decode: skips prefixes, finds opcode and ModRM, picks out the disp32 and
// forms orig - copy.
// ----------------------------------------------------------------------------
module rrel_front #(
  parameter int INSN_BYTES = rrel_pkg::INSN_BYTES_DEF
) (
  input  wire rrel_pkg::in_item_t in_item,
  output rrel_pkg::mid_item_t     dec_item
);

  import rrel_pkg::*;

  localparam int W = (INSN_BYTES > 16) ? 16 : INSN_BYTES;
  localparam logic [4:0] W5 = 5'(W);
  localparam logic [5:0] W6 = 6'(W);

  logic [255:0] ext;
  logic [7:0]   win [32];
  logic [4:0]   pos, p1, p2, off;
  logic         found, rex, esc, need, modrm_ok, fits, riprel;
  logic [7:0]   op, modrm;
  logic [31:0]  disp;

  assign ext = {136'b0, in_item.insn_high, in_item.insn_low};

  // decode view: zero at and past the window end
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      win[i] = (i < W) ? ext[8*i +: 8] : 8'h00;
    end
  end

  // first non-prefix byte inside the window
  always_comb begin
    pos = W5;
    for (int i = W - 1; i >= 0; i--) begin
      if (!is_legacy_prefix(win[i])) begin
        pos = 5'(i);
      end
    end
  end

  assign found    = (pos < W5);
  assign rex      = ((win[pos] & REX_MASK) == REX_BASE);
  assign p1       = pos + {4'b0, rex};
  assign esc      = (win[p1] == OP_ESCAPE);
  assign p2       = p1 + {4'b0, esc};
  assign op       = win[p2];
  assign need     = esc ? TWO_MODRM[op[7:4]][op[3:0]] : ONE_MODRM[op[7:4]][op[3:0]];
  assign modrm    = win[p2 + 5'd1];
  assign modrm_ok = ((modrm & MODRM_MASK) == MODRM_RIPREL);
  assign off      = p2 + 5'd2;
  assign fits     = ({1'b0, off} + 6'd4) <= W6;
  assign riprel   = found && need && modrm_ok && fits;
  assign disp     = {win[off + 5'd3], win[off + 5'd2], win[off + 5'd1], win[off]};

  always_comb begin
    dec_item              = '0;
    dec_item.rip_relative = riprel;
    dec_item.disp_offset  = riprel ? off[3:0] : 4'd0;
    dec_item.disp         = disp;
    dec_item.delta        = in_item.orig_address - in_item.copy_address;
    dec_item.insn_low     = in_item.insn_low;
    dec_item.insn_high    = in_item.insn_high;
  end

endmodule
`default_nettype wire

>>> rtl/rrel_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrel_back
// Relocation: adds the displacement, checks the signed 32-bit range and
// patches the bytes.
// ----------------------------------------------------------------------------
module rrel_back (
  input  wire rrel_pkg::mid_item_t dec_item,
  output rrel_pkg::out_item_t      res_item
);

  import rrel_pkg::*;

  logic [63:0]  sum;
  logic [31:0]  nd;
  logic         oor, do_patch;
  logic [119:0] bytes_in, bytes_out;
  logic [4:0]   rel;
  logic [31:0]  nd_sh;

  assign sum = dec_item.delta + {{32{dec_item.disp[31]}}, dec_item.disp};
  assign nd  = sum[31:0];
  // fits only when bits 63:31 are all equal
  assign oor = !((sum[63:31] == '0) || (sum[63:31] == '1));
  assign do_patch = dec_item.rip_relative && !oor;
  assign bytes_in = {dec_item.insn_high, dec_item.insn_low};

  always_comb begin
    bytes_out = bytes_in;
    rel       = '0;
    nd_sh     = '0;
    for (int k = 0; k < 15; k++) begin
      rel   = 5'(k) - {1'b0, dec_item.disp_offset};
      nd_sh = nd >> {rel[1:0], 3'b000};
      if (do_patch && (rel < 5'd4)) begin
        bytes_out[8*k +: 8] = nd_sh[7:0];
      end
    end
  end

  always_comb begin
    res_item              = '0;
    res_item.rip_relative = dec_item.rip_relative;
    res_item.disp_offset  = dec_item.disp_offset;
    res_item.new_disp     = dec_item.rip_relative ? nd : 32'd0;
    res_item.out_of_range = dec_item.rip_relative && oor;
    res_item.patched_low  = bytes_out[63:0];
    res_item.patched_high = bytes_out[119:64];
  end

endmodule
`default_nettype wire

>>> rtl/riprel_displacement_relocate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riprel_displacement_relocate
// x86-64 rip-relative displacement relocator: decode front, decode queue,
// relocation back, result queue.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------
//  in_      | in_push / in_full  | in_item  (insn bytes, addresses)
//  out_     | out_pop / out_empty| out_item (flags, disp, patched)
//
// One instruction per cycle sustained while out_pop keeps pace; a result is
// registered in the decode queue, then in the result queue, before it is visible.
// Synchronous active-low reset empties both queues.
// A stalled result side fills the result queue, then the decode queue,
// and only then raises in_full.
// ----------------------------------------------------------------------------
module riprel_displacement_relocate #(
  parameter int INSN_BYTES = rrel_pkg::INSN_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire rrel_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output rrel_pkg::out_item_t      out_item
);

  import rrel_pkg::*;

  mid_item_t dec_item, mid_head;
  out_item_t res_item;
  logic      mid_empty, res_full, move;

  rrel_front #(.INSN_BYTES(INSN_BYTES)) u_front (
    .in_item  (in_item),
    .dec_item (dec_item)
  );

  rrel_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (dec_item),
    .pop   (move),
    .empty (mid_empty),
    .rdata (mid_head)
  );

  rrel_back u_back (
    .dec_item (mid_head),
    .res_item (res_item)
  );

  assign move = !mid_empty && !res_full;

  rrel_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (move),
    .full  (res_full),
    .wdata (res_item),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_item)
  );

endmodule
`default_nettype wire
